@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the wind grid interpolator.
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequence checked in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wgi_pkg.sv @@
// Package of the wind grid interpolator: grid sizes, widths, codes, state types
// and the grid address function. No dependencies.
package wgi_pkg;

    localparam int HOURS  = 8;
    localparam int LEVELS = 16;
    localparam int LATS   = 32;
    localparam int LONS   = 64;
    localparam int NQUANT = 3;

    localparam int H_W   = $clog2(HOURS);
    localparam int L_W   = $clog2(LEVELS);
    localparam int R_W   = $clog2(LATS);
    localparam int C_W   = $clog2(LONS);
    localparam int Q_W   = 2;
    localparam int HLQ_W = $clog2(HOURS * LEVELS * NQUANT);
    localparam int ADDR_W    = HLQ_W + R_W + C_W;
    localparam int MEM_DEPTH = HOURS * LEVELS * NQUANT * LATS * LONS;

    // divider: dividend carries a 16 bit fraction below the integer part
    localparam int DIV_NW = 51;
    localparam int DIV_DW = 35;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam int BL_W  = 34;   // spatially blended value, signed, same scale as the grid samples (Q.0)
    localparam int ACC_W = 54;   // sum of eight sample * weight products
    localparam int W_W   = 26;   // altitude weight, Q.16 signed, clamped

    localparam int W_ONE   = 65536;
    localparam int W_HALF  = 32768;
    localparam int W_CLAMP = 16777216;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 88;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [Q_W-1:0] Q_HEIGHT = 2'd0;
    localparam logic [Q_W-1:0] Q_U      = 2'd1;
    localparam logic [Q_W-1:0] Q_V      = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HOUR = 2'd1;
    localparam logic [1:0] ST_LAT  = 2'd2;
    localparam logic [1:0] ST_LNG  = 2'd3;

    localparam logic [1:0] CFG_HOUR_STEP  = 2'd0;
    localparam logic [1:0] CFG_LAT_ORIGIN = 2'd1;
    localparam logic [1:0] CFG_LAT_STEP   = 2'd2;
    localparam logic [1:0] CFG_LNG_STEP   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_H, S_DIV_A, S_DIV_N, S_WT1, S_WT2, S_SRCH, S_BLEND,
        S_WDIV, S_MULA, S_MULB, S_SUM, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_SRCH, PH_LH, PH_UH, PH_A, PH_B
    } t_phase;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    function automatic logic [ADDR_W-1:0] grid_addr(
        input logic [H_W-1:0] h,
        input logic [L_W-1:0] lev,
        input logic [Q_W-1:0] q,
        input logic [R_W-1:0] r,
        input logic [C_W-1:0] c
    );
        logic [HLQ_W-1:0] hlq;
        hlq = (HLQ_W'(h) * HLQ_W'(LEVELS) + HLQ_W'(lev)) * HLQ_W'(NQUANT) + HLQ_W'(q);
        return {hlq, r, c};
    endfunction

endpackage

@@ rtl/wgi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wgi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wgi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wgi_pkg::t_div_req i_req,
    output wgi_pkg::t_div_rsp o_rsp
);
    import wgi_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    `ASSERT_IMPL(a_start_idle, i_req.start, !r_busy, "divider started while busy")
    `ASSERT_NEXT(a_done_pulse, r_done, !r_done && !r_busy, "divider done held")
    `ASSERT_IMPL(a_cnt_live, r_busy, r_cnt != '0, "divider busy with empty count")

endmodule

@@ rtl/wind_grid_4d_interpolator.sv @@
// Top level of the wind grid interpolator: grid memory, query sequencer, blend datapath.
// Depends on wgi_pkg, wgi_div and assert_macros.svh.
//
// One beat in, one beat out. A grid write passes through the S_OUT state and the output
// register to its result beat. A query runs up to three axis divisions and one altitude
// weight division in the shared bit-serial divider, then up to ten spatial blends (eight
// corner reads through the single read port of the grid memory, a product stage and an
// accumulate stage), up to four for the level search and six for the height bracket and
// the u and v blends. Out of range queries end at the failing axis check.
// The block takes a new beat only while idle; a result waiting in the output register
// does not block it. The grid memory needs no clearing after reset.
`include "assert_macros.svh"

module wind_grid_4d_interpolator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // grid_hour, grid_level, grid_quantity, grid_row, grid_column, grid_value,
    // query_hour, query_lat, query_lng, query_alt, zero pad
    input  logic [wgi_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // func
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // wind_u, wind_v, status, above_top, above_top_total, zero pad
    output logic [wgi_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [15:0]                      i_cfg_data
);
    import wgi_pkg::*;

    localparam int LIM_W = DIV_NW - 16;
    localparam logic [L_W-1:0] LO_MAX = L_W'(LEVELS - 2);
    localparam logic [3:0] BC_LAST = 4'd10;
    localparam logic signed [44:0] SAT_MAX = 45'sd2147483647;
    localparam logic signed [44:0] SAT_MIN = -45'sd2147483648;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [15:0] r_hour_step, r_lat_origin, r_lat_step, r_lng_step;
    logic [15:0] r_qhour, r_qlat;
    logic [16:0] r_qlng;
    logic [23:0] r_qalt;

    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_rdata;

    logic [H_W-1:0] r_ih;
    logic [R_W-1:0] r_ia;
    logic [C_W-1:0] r_in0;
    logic [15:0]    r_fh, r_fa, r_fn;
    logic [16:0]    r_t  [4];
    logic [16:0]    r_wt [8];

    logic [L_W-1:0] r_lo, r_hi, r_lev;
    logic [Q_W-1:0] r_q;
    logic [3:0]     r_bc;
    logic [2:0]     r_k1;
    logic           r_v1, r_v2;
    logic signed [49:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [BL_W-1:0]  r_lh, r_uh, r_ba, r_bb;
    logic signed [W_W-1:0]   r_w;
    logic signed [59:0]      r_pa, r_pb;
    logic [31:0]    r_u, r_v;
    logic [1:0]     r_status;
    logic           r_above;
    logic [15:0]    r_cnt;

    logic                    r_m_tvalid;
    logic [OUT_TDATA_W-1:0]  r_m_tdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic accept, is_query, mem_we, out_load, blend_done;
    logic [Q_W-1:0]    wr_q;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [C_W-1:0]    in1;
    logic [16:0]       off_a;
    logic [16:0]       ax_off;
    logic [15:0]       ax_step;
    logic              ax_neg, ax_bad, lim_bad, in_ax;
    logic [LIM_W-1:0]  ax_lim;
    logic [1:0]        ax_st;
    logic [16:0]       wh [2];
    logic [16:0]       wa [2];
    logic [16:0]       wn [2];
    logic [L_W:0]      mid_sum;
    logic [L_W-1:0]    mid;
    logic signed [ACC_W-1:0] acc_r, acc_sh;
    logic signed [BL_W-1:0]  bl, alt_s;
    logic              alt_le;
    logic signed [BL_W:0]    num, den;
    logic [BL_W:0]     num_mag, den_mag;
    logic [W_W-1:0]    wmag;
    logic              w_neg, w_above, heights_eq;
    logic signed [W_W-1:0]   w_calc, wc;
    logic signed [60:0]      psum;
    logic signed [44:0]      rnd;
    logic [31:0]       sat;

    wgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_query   = (i_s_tuser == FUNC_QUERY);
    assign wr_q       = i_s_tdata[8:7];
    assign mem_we     = accept && !is_query && (wr_q < Q_W'(NQUANT));
    assign wr_addr    = grid_addr(i_s_tdata[2:0], i_s_tdata[6:3], wr_q,
                                  i_s_tdata[13:9], i_s_tdata[19:14]);

    // corner k: hour pair from bit 2, latitude pair from bit 1, longitude pair from bit 0
    assign in1     = (r_in0 == C_W'(LONS - 1)) ? '0 : r_in0 + 1'b1;
    assign rd_addr = grid_addr(r_ih + H_W'(r_bc[2]), r_lev, r_q, r_ia + R_W'(r_bc[1]),
                               r_bc[0] ? in1 : r_in0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_s_tdata[51:20];
        end
        r_rdata <= r_mem[rd_addr];
    end

    // axis split operands
    assign off_a = {r_qlat[15], r_qlat} - {r_lat_origin[15], r_lat_origin};
    assign in_ax = (r_state == S_DIV_H) || (r_state == S_DIV_A) || (r_state == S_DIV_N);

    always_comb begin
        ax_off  = {1'b0, r_qhour};
        ax_step = r_hour_step;
        ax_neg  = 1'b0;
        ax_lim  = LIM_W'(HOURS - 1);
        ax_st   = ST_HOUR;
        case (r_state)
            S_DIV_A: begin
                ax_off  = off_a;
                ax_step = r_lat_step;
                ax_neg  = off_a[16];
                ax_lim  = LIM_W'(LATS - 1);
                ax_st   = ST_LAT;
            end
            S_DIV_N: begin
                ax_off  = r_qlng;
                ax_step = r_lng_step;
                ax_lim  = LIM_W'(LONS);
                ax_st   = ST_LNG;
            end
            default: begin
            end
        endcase
    end

    assign ax_bad  = (ax_step == '0) || ax_neg;
    assign lim_bad = div_rsp.quo[DIV_NW-1:16] >= ax_lim;

    // altitude weight operands
    assign alt_s      = {(BL_W - 24)'(0), r_qalt};
    assign num        = {r_uh[BL_W-1], r_uh} - {alt_s[BL_W-1], alt_s};
    assign den        = {r_uh[BL_W-1], r_uh} - {r_lh[BL_W-1], r_lh};
    assign num_mag    = num[BL_W] ? -num : num;
    assign den_mag    = den[BL_W] ? -den : den;
    assign heights_eq = (r_lh == r_uh);
    assign wmag       = (div_rsp.quo > DIV_NW'(W_CLAMP)) ? W_W'(W_CLAMP)
                                                         : div_rsp.quo[W_W-1:0];
    assign w_neg      = num[BL_W] ^ den[BL_W];
    assign w_calc     = w_neg ? -$signed(wmag) : $signed(wmag);
    assign w_above    = w_neg && (wmag != '0);

    always_comb begin
        div_req.start    = !div_rsp.busy && !div_rsp.done &&
                           ((in_ax && !ax_bad) || ((r_state == S_WDIV) && !heights_eq));
        div_req.dividend = (r_state == S_WDIV) ? DIV_NW'({num_mag[BL_W-1:0], 16'h0})
                                               : DIV_NW'({ax_off, 16'h0});
        div_req.divisor  = (r_state == S_WDIV) ? DIV_DW'(den_mag) : DIV_DW'(ax_step);
    end

    // pair weights
    assign wh[0] = 17'(W_ONE) - {1'b0, r_fh};
    assign wh[1] = {1'b0, r_fh};
    assign wa[0] = 17'(W_ONE) - {1'b0, r_fa};
    assign wa[1] = {1'b0, r_fa};
    assign wn[0] = 17'(W_ONE) - {1'b0, r_fn};
    assign wn[1] = {1'b0, r_fn};

    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign mid        = mid_sum[L_W:1];
    assign blend_done = (r_state == S_BLEND) && (r_bc == BC_LAST);
    assign acc_r      = r_acc + ACC_W'(W_HALF);
    assign acc_sh     = acc_r >>> 16;
    assign bl         = acc_sh[BL_W-1:0];
    assign alt_le     = alt_s <= bl;

    assign wc   = W_W'(W_ONE) - r_w;
    assign psum = {r_pa[59], r_pa} + {r_pb[59], r_pb} + 61'sd32768;
    assign rnd  = psum[60:16];
    assign sat  = (rnd > SAT_MAX) ? 32'h7FFF_FFFF :
                  (rnd < SAT_MIN) ? 32'h8000_0000 : rnd[31:0];

    assign out_load = (r_state == S_OUT) && (!r_m_tvalid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = is_query ? S_DIV_H : S_OUT;
            S_DIV_H: begin
                if (ax_bad) n_state = S_OUT;
                else if (div_rsp.done) n_state = lim_bad ? S_OUT : S_DIV_A;
            end
            S_DIV_A: begin
                if (ax_bad) n_state = S_OUT;
                else if (div_rsp.done) n_state = lim_bad ? S_OUT : S_DIV_N;
            end
            S_DIV_N: begin
                if (ax_bad) n_state = S_OUT;
                else if (div_rsp.done) n_state = lim_bad ? S_OUT : S_WT1;
            end
            S_WT1:   n_state = S_WT2;
            S_WT2:   n_state = S_SRCH;
            S_SRCH:  n_state = S_BLEND;
            S_BLEND: begin
                if (blend_done) begin
                    case (r_phase)
                        PH_SRCH: n_state = S_SRCH;
                        PH_UH:   n_state = S_WDIV;
                        PH_B:    n_state = S_MULA;
                        default: n_state = S_BLEND;
                    endcase
                end
            end
            S_WDIV:  if (heights_eq || div_rsp.done) n_state = S_BLEND;
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_SUM;
            S_SUM:   n_state = (r_q == Q_U) ? S_BLEND : S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hour_step  <= 16'd768;
            r_lat_origin <= 16'hA600;
            r_lat_step   <= 16'd128;
            r_lng_step   <= 16'd128;
            r_cnt        <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_m_tvalid   <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HOUR_STEP:  r_hour_step  <= i_cfg_data;
                    CFG_LAT_ORIGIN: r_lat_origin <= i_cfg_data;
                    CFG_LAT_STEP:   r_lat_step   <= i_cfg_data;
                    CFG_LNG_STEP:   r_lng_step   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_lo <= '0;
                r_hi <= LO_MAX;
            end else if (blend_done && (r_phase == PH_SRCH)) begin
                if (alt_le) r_hi <= r_lev - 1'b1;
                else r_lo <= r_lev;
            end
            if ((r_state == S_WDIV) && !heights_eq && div_rsp.done && w_above &&
                (r_cnt != 16'hFFFF)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (out_load) r_m_tvalid <= 1'b1;
            else if (i_m_tready) r_m_tvalid <= 1'b0;
            r_v1 <= (r_state == S_BLEND) && !r_bc[3];
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qhour  <= i_s_tdata[67:52];
            r_qlat   <= i_s_tdata[83:68];
            r_qlng   <= i_s_tdata[100:84];
            r_qalt   <= i_s_tdata[124:101];
            r_u      <= '0;
            r_v      <= '0;
            r_above  <= 1'b0;
            r_status <= ST_OK;
        end
        if (in_ax && (ax_bad || (div_rsp.done && lim_bad))) r_status <= ax_st;
        if (div_rsp.done) begin
            case (r_state)
                S_DIV_H: begin
                    r_ih <= div_rsp.quo[16 +: H_W];
                    r_fh <= div_rsp.quo[15:0];
                end
                S_DIV_A: begin
                    r_ia <= div_rsp.quo[16 +: R_W];
                    r_fa <= div_rsp.quo[15:0];
                end
                S_DIV_N: begin
                    r_in0 <= div_rsp.quo[16 +: C_W];
                    r_fn  <= div_rsp.quo[15:0];
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_WT1) begin
            for (int i = 0; i < 4; i++) begin
                r_t[i] <= 17'(((wh[i/2] * wa[i%2]) + 34'd32768) >> 16);
            end
        end
        if (r_state == S_WT2) begin
            for (int k = 0; k < 8; k++) begin
                r_wt[k] <= 17'(((r_t[k/2] * wn[k%2]) + 34'd32768) >> 16);
            end
        end

        // blend pipeline: read, multiply, accumulate
        r_bc   <= ((r_state != S_BLEND) || blend_done) ? 4'd0 : r_bc + 1'b1;
        r_k1   <= r_bc[2:0];
        r_prod <= $signed(r_rdata) * $signed({1'b0, r_wt[r_k1]});
        if ((r_state != S_BLEND) || blend_done) r_acc <= '0;
        else if (r_v2) r_acc <= r_acc + ACC_W'(r_prod);

        case (r_state)
            S_SRCH: begin
                r_q <= Q_HEIGHT;
                if (r_lo < r_hi) begin
                    r_lev   <= mid;
                    r_phase <= PH_SRCH;
                end else begin
                    r_lev   <= r_lo;
                    r_phase <= PH_LH;
                end
            end
            S_BLEND: begin
                if (blend_done) begin
                    case (r_phase)
                        PH_LH: begin
                            r_lh    <= bl;
                            r_lev   <= r_lo + 1'b1;
                            r_phase <= PH_UH;
                        end
                        PH_UH: r_uh <= bl;
                        PH_A: begin
                            r_ba    <= bl;
                            r_lev   <= r_lo + 1'b1;
                            r_phase <= PH_B;
                        end
                        PH_B:    r_bb <= bl;
                        default: begin
                        end
                    endcase
                end
            end
            S_WDIV: begin
                r_lev   <= r_lo;
                r_q     <= Q_U;
                r_phase <= PH_A;
                if (heights_eq) begin
                    r_w <= W_W'(W_HALF);
                end else if (div_rsp.done) begin
                    r_w     <= w_calc;
                    r_above <= w_above;
                end
            end
            S_MULA: r_pa <= r_ba * r_w;
            S_MULB: r_pb <= r_bb * wc;
            S_SUM: begin
                if (r_q == Q_U) begin
                    r_u     <= sat;
                    r_q     <= Q_V;
                    r_lev   <= r_lo;
                    r_phase <= PH_A;
                end else begin
                    r_v <= sat;
                end
            end
            default: begin
            end
        endcase

        if (out_load) begin
            r_m_tdata <= {5'b0, r_cnt, r_above, r_status, r_v, r_u};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    `ASSERT_NEXT(a_cnt_hold, r_state != S_WDIV, $stable(r_cnt), "above-top count moved")
    `ASSERT_ALWAYS(a_band, (r_lo <= LO_MAX) && (r_hi <= LO_MAX), "level bracket out of range")
    `ASSERT_IMPL(a_w_range, r_state == S_MULA,
                 (r_w <= W_W'(W_CLAMP)) && (r_w >= -W_W'(W_CLAMP)), "weight beyond clamp")
    `ASSERT_IMPL(a_out_busy, r_state == S_IDLE, !div_rsp.busy, "divider busy while idle")

endmodule

@@ dv/wind_grid_4d_interpolator_test.sv @@
// Self-checking testbench of wind_grid_4d_interpolator: stream driver, config writer and
// a scoreboard class that predicts every result beat. Depends on wgi_pkg and the RTL.
module wind_grid_4d_interpolator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wgi_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        logic               op;
        logic [2:0]         g_hour;
        logic [3:0]         g_level;
        logic [1:0]         g_qty;
        logic [4:0]         g_row;
        logic [5:0]         g_col;
        logic signed [31:0] g_value;
        logic [15:0]        q_hour;
        logic signed [15:0] q_lat;
        logic [16:0]        q_lng;
        logic [23:0]        q_alt;
    } beat_t;

    typedef struct {
        logic signed [31:0] wind_u;
        logic signed [31:0] wind_v;
        logic [1:0]         status;
        logic               above_top;
        logic [15:0]        total;
    } wind_t;

    class wind_scoreboard;
        int     grid[int];
        longint hour_step, lat_origin, lat_step, lng_step;
        logic [15:0] top_count;
        wind_t  wind_q[$];
        int     errors;
        int     c_h[8], c_a[8], c_n[8];
        longint c_w[8];

        function new();
            hour_step = 768; lat_origin = -23040; lat_step = 128; lng_step = 128;
            top_count = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                CFG_HOUR_STEP:  hour_step = v;
                CFG_LAT_ORIGIN: lat_origin = longint'($signed(v));
                CFG_LAT_STEP:   lat_step = v;
                CFG_LNG_STEP:   lng_step = v;
            endcase
        endfunction

        function int cell_key(int h, int l, int q, int r, int c);
            return ((((h * LEVELS + l) * NQUANT + q) * LATS + r) * LONS) + c;
        endfunction

        function longint sample(int h, int l, int q, int r, int c);
            int k;
            k = cell_key(h, l, q, r, c);
            return grid.exists(k) ? longint'(grid[k]) : 0;
        endfunction

        function longint rnd16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function bit split(longint off, longint stp, longint lim, output int idx,
                           output longint fr);
            longint q;
            if (stp == 0 || off < 0) return 0;
            q = off / stp;
            if (q >= lim) return 0;
            idx = int'(q);
            fr = ((off - q * stp) * 65536) / stp;
            return 1;
        endfunction

        // fills the eight corners; returns the query status
        function logic [1:0] locate(beat_t b);
            int ih, ia, in0, in1, k;
            longint fh, fa, fn, t;
            longint wh[2], wa[2], wn[2];
            if (!split(longint'(b.q_hour), hour_step, HOURS - 1, ih, fh)) return ST_HOUR;
            if (!split(longint'(b.q_lat) - lat_origin, lat_step, LATS - 1, ia, fa))
                return ST_LAT;
            if (!split(longint'(b.q_lng), lng_step, LONS, in0, fn)) return ST_LNG;
            in1 = (in0 + 1 >= LONS) ? 0 : in0 + 1;
            wh = '{W_ONE - fh, fh}; wa = '{W_ONE - fa, fa}; wn = '{W_ONE - fn, fn};
            k = 0;
            for (int x = 0; x < 2; x++)
                for (int y = 0; y < 2; y++)
                    for (int z = 0; z < 2; z++) begin
                        t = (wh[x] * wa[y] + 32768) >>> 16;
                        c_h[k] = ih + x; c_a[k] = ia + y; c_n[k] = z ? in1 : in0;
                        c_w[k] = (t * wn[z] + 32768) >>> 16;
                        k++;
                    end
            return ST_OK;
        endfunction

        // a query may only touch cells that were written
        function bit query_safe(beat_t b);
            if (locate(b) != ST_OK) return 1;
            for (int k = 0; k < 8; k++)
                for (int l = 0; l < LEVELS; l++)
                    for (int q = 0; q < NQUANT; q++)
                        if (!grid.exists(cell_key(c_h[k], l, q, c_a[k], c_n[k]))) return 0;
            return 1;
        endfunction

        function longint blend(int q, int lev);
            longint acc;
            acc = 0;
            for (int k = 0; k < 8; k++)
                acc += sample(c_h[k], lev, q, c_a[k], c_n[k]) * c_w[k];
            return rnd16(acc);
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function longint alt_mix(int q, int band, longint w);
            return rnd16(blend(q, band) * w + blend(q, band + 1) * (W_ONE - w));
        endfunction

        function void note_input(beat_t b);
            wind_t  e;
            int     lo, hi, m, band;
            longint alt, lh, uh, w;
            e = '{0, 0, ST_OK, 0, 0};
            if (b.op == FUNC_WRITE) begin
                if (b.g_qty < NQUANT)
                    grid[cell_key(b.g_hour, b.g_level, b.g_qty, b.g_row, b.g_col)] = b.g_value;
            end else begin
                e.status = locate(b);
                if (e.status == ST_OK) begin
                    alt = b.q_alt;
                    lo = 0; hi = LEVELS - 2;
                    while (lo < hi) begin
                        m = (lo + hi + 1) / 2;
                        if (alt <= blend(Q_HEIGHT, m)) hi = m - 1;
                        else lo = m;
                    end
                    band = lo;
                    lh = blend(Q_HEIGHT, band);
                    uh = blend(Q_HEIGHT, band + 1);
                    if (lh == uh) w = W_HALF;
                    else begin
                        w = ((uh - alt) * 65536) / (uh - lh);
                        if (w > W_CLAMP) w = W_CLAMP;
                        if (w < -W_CLAMP) w = -W_CLAMP;
                    end
                    if (w < 0) begin
                        e.above_top = 1;
                        if (top_count != 16'hFFFF) top_count++;
                    end
                    e.wind_u = sat32(alt_mix(Q_U, band, w));
                    e.wind_v = sat32(alt_mix(Q_V, band, w));
                end
            end
            e.total = top_count;
            wind_q.push_back(e);
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            wind_t e;
            if (wind_q.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
                return;
            end
            e = wind_q.pop_front();
            cmp("wind_u", e.wind_u, $signed(d[31:0]));
            cmp("wind_v", e.wind_v, $signed(d[63:32]));
            cmp("status", e.status, d[65:64]);
            cmp("above_top", e.above_top, d[66]);
            cmp("above_top_total", e.total, d[82:67]);
        endfunction

        function int pending();
            return wind_q.size();
        endfunction
    endclass

    logic clk, rst_n;
    logic s_tvalid, s_tuser, m_tready, cfg_we;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic o_s_tready, o_m_tvalid;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    wind_scoreboard sb = new();
    int idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both
    int hold_cycles;
    int quiet;
    int cols[3] = '{63, 0, 1};

    wind_grid_4d_interpolator i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stalls plus one long hold-off when requested
    initial begin
        m_tready = 0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready = 0;
            end else if (idle_mode == 2)
                m_tready = $urandom_range(99) >= 82;
            else if (idle_mode == 3)
                m_tready = $urandom_range(99) >= 14;
            else
                m_tready = 1;
        end
    end

    always @(posedge clk)
        if (rst_n && o_m_tvalid && m_tready) sb.check_result(m_tdata);

    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || cfg_we || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic beat_t rand_beat();
        beat_t b;
        b.op = $urandom; b.g_hour = $urandom; b.g_level = $urandom; b.g_qty = $urandom;
        b.g_row = $urandom; b.g_col = $urandom; b.g_value = $urandom;
        b.q_hour = $urandom; b.q_lat = $urandom; b.q_lng = $urandom; b.q_alt = $urandom;
        return b;
    endfunction

    function automatic int height_for(int lev);
        return lev * 768000 + int'($urandom_range(200000));
    endfunction

    task automatic send(beat_t b);
        @(negedge clk);
        while ((idle_mode == 1 && $urandom_range(99) < 82) ||
               (idle_mode == 3 && $urandom_range(99) < 14)) begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = b.op;
        s_tdata = {3'b0, b.q_alt, b.q_lng, b.q_lat, b.q_hour, b.g_value, b.g_col,
                   b.g_row, b.g_qty, b.g_level, b.g_hour};
        do @(posedge clk); while (!o_s_tready);
        sb.note_input(b);
    endtask

    task automatic write_grid(int h, int l, int q, int r, int c, int v);
        beat_t b;
        b = rand_beat();
        b.op = FUNC_WRITE;
        b.g_hour = h; b.g_level = l; b.g_qty = q; b.g_row = r; b.g_col = c; b.g_value = v;
        send(b);
    endtask

    task automatic query(int qh, int qlat, int qlng, int qalt);
        beat_t b;
        b = rand_beat();
        b.op = FUNC_QUERY;
        b.q_hour = qh; b.q_lat = qlat; b.q_lng = qlng; b.q_alt = qalt;
        send(b);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_regs(logic [15:0] hs, logic [15:0] lo, logic [15:0] ls,
                              logic [15:0] ns);
        logic [15:0] vals[4];
        vals = '{hs, lo, ls, ns};
        for (int i = 0; i < 4; i++) begin
            cfg_we = 1; cfg_idx = i; cfg_data = vals[i];
            sb.set_reg(i, vals[i]);
            @(negedge clk);
        end
        cfg_we = 0;
    endtask

    // mostly in-region queries that land on written cells; the rest writes and noise
    function automatic beat_t make_beat();
        beat_t  b;
        int     k;
        longint v;
        b = rand_beat();
        k = $urandom_range(99);
        if (k < 20) begin
            b.op = FUNC_WRITE;
            if (k < 10) begin
                b.g_hour = $urandom_range(1); b.g_row = $urandom_range(1);
                b.g_col = cols[$urandom_range(2)]; b.g_qty = $urandom_range(2);
                if (b.g_qty == Q_HEIGHT && $urandom_range(3) != 0)
                    b.g_value = height_for(b.g_level);
                else if (b.g_qty != Q_HEIGHT && $urandom_range(3) != 0)
                    b.g_value = int'($urandom_range(10000000)) - 5000000;
            end
        end else begin
            b.op = FUNC_QUERY;
            if (k >= 32) begin
                if (sb.hour_step != 0) b.q_hour = $urandom_range(sb.hour_step - 1);
                v = sb.lat_origin + (sb.lat_step != 0 ? $urandom_range(sb.lat_step - 1) : 0);
                if (v >= -23040 && v <= 23040) b.q_lat = v;
                v = ($urandom_range(1) ? 63 : 0) * sb.lng_step;
                if (sb.lng_step != 0) v += $urandom_range(sb.lng_step - 1);
                if (v <= 92159) b.q_lng = v;
                case ($urandom_range(9))
                    0: b.q_alt = 0;
                    1: b.q_alt = 24'hFFFFFF;
                    2, 3: b.q_alt = $urandom_range(16777215, 12000000);
                    default: b.q_alt = $urandom_range(11800000);
                endcase
            end
            if (!sb.query_safe(b)) b.op = FUNC_WRITE;
        end
        return b;
    endfunction

    task automatic run_phase(int n, int mode, bit squeeze);
        idle_mode = mode;
        for (int i = 0; i < n; i++) begin
            if (squeeze && i == 30) hold_cycles = 1500;
            send(make_beat());
        end
        drain();
    endtask

    initial begin
        rst_n = 0; s_tvalid = 0; s_tuser = 0; s_tdata = '0;
        cfg_we = 0; cfg_idx = '0; cfg_data = '0;
        idle_mode = 0; hold_cycles = 0; quiet = 0;
        repeat (2) @(negedge clk);
        rst_n = 1;

        // load hours 0-1, rows 0-1 and the columns around the longitude seam
        for (int h = 0; h < 2; h++)
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 3; c++)
                    for (int l = 0; l < LEVELS; l++) begin
                        write_grid(h, l, Q_HEIGHT, r, cols[c], height_for(l));
                        write_grid(h, l, Q_U, r, cols[c],
                                   int'($urandom_range(10000000)) - 5000000);
                        write_grid(h, l, Q_V, r, cols[c],
                                   int'($urandom_range(10000000)) - 5000000);
                    end

        // directed, reset register values
        write_grid(0, 0, 3, 0, 0, 32'h12345678);          // quantity 3 is dropped
        write_grid(0, 5, Q_U, 0, 0, 32'h7FFFFFFF);
        write_grid(0, 5, Q_V, 0, 0, 32'h80000000);
        query(0, -23040, 0, 5 * 768000 + 100000);         // saturating blend
        query(0, -23040, 0, 0);
        query(767, -23040 + 127, 127, 24'hFFFFFF);        // top fractions, above top
        query(384, -23040 + 64, 63 * 128 + 127, 3000000); // longitude wraps to column 0
        query(0, -23040, 63 * 128, 7000000);
        query(65535, 0, 0, 0);                            // hour out of range
        query(0, 23040, 0, 0);                            // latitude out of range
        query(0, -23040, 92159, 0);                       // longitude out of range
        query(0, -23040, 65536, 0);
        write_grid(0, 0, Q_HEIGHT, 0, 0, 100000);         // equal heights at the bottom
        write_grid(0, 1, Q_HEIGHT, 0, 0, 100000);
        query(0, -23040, 0, 50000);
        write_grid(1, 1, Q_HEIGHT, 1, 1, height_for(1));
        drain();

        write_regs(768, -16'sd23040, 128, 128);
        run_phase(220, 0, 1);
        write_regs(1, 23040, 1, 1);
        run_phase(120, 1, 0);
        write_regs(16'hFFFF, -16'sd23040, 16'hFFFF, 16'hFFFF);
        run_phase(150, 2, 0);
        write_regs(300, -16'sd100, 1000, 500);            // negative latitude offsets
        run_phase(180, 3, 0);
        write_regs(0, 0, 0, 0);
        run_phase(25, 0, 0);
        write_regs(768, -16'sd23040, 0, 128);
        run_phase(25, 1, 0);
        write_regs(768, -16'sd23040, 128, 0);
        run_phase(25, 2, 0);
        write_regs(768, -16'sd23040, 128, 128);
        run_phase(150, 3, 0);
        write_regs(512, -16'sd1000, 300, 200);
        run_phase(100, 0, 0);

        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
